/* hdl/tsts_pkg.sv */
// Shared types and constants for the top-score table sorter.
// No dependencies; used by top_score_table_sorter.
package tsts_pkg;

  localparam int SCORE_W  = 24;
  localparam int RANK_W   = 6;
  localparam int OP_W     = 2;
  localparam int MAX_EMIT = 64;

  typedef logic [SCORE_W-1:0] score_t;
  typedef logic [RANK_W-1:0]  rank_t;
  typedef logic [OP_W-1:0]    op_t;

  localparam op_t OP_LOAD   = 2'd0;
  localparam op_t OP_SUBMIT = 2'd1;
  localparam op_t OP_SORT   = 2'd2;
  localparam op_t OP_LIST   = 2'd3;

endpackage

/* hdl/top_score_table_sorter.sv */
// Top-score table sorter: score memory, bubble sort sequencer and output register.
// Depends on tsts_pkg.
//
// Sort of n entries is a bubble sort, limited by the single compare unit and the one-write
// memory port. Submit reads and compares the last kept place before the sort when no place
// is free; each emitted word is read from memory, then registered once the output reg is free.
// One input word at a time; the next is taken once the last result sits in the output reg.
// Reset (rst, synchronous) empties the table and drops out_valid; memory is not cleared.
module top_score_table_sorter #(
  parameter int TABLE_DEPTH = 64,
  parameter int KEEP_LIMIT  = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tsts_pkg::op_t        operation,
  input  tsts_pkg::score_t     score_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tsts_pkg::rank_t      rank,
  output tsts_pkg::score_t     score_out,
  output logic                 last
);

  localparam int AW        = $clog2(TABLE_DEPTH);
  localparam int CW        = $clog2(TABLE_DEPTH + 1);
  localparam int PLACE_LIM = (KEEP_LIMIT < TABLE_DEPTH) ? KEEP_LIMIT : TABLE_DEPTH;

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_SUB_RD     = 4'd1;
  localparam logic [3:0] S_SUB_CMP    = 4'd2;
  localparam logic [3:0] S_SORT_START = 4'd3;
  localparam logic [3:0] S_SORT_FIRST = 4'd4;
  localparam logic [3:0] S_SORT_RUN   = 4'd5;
  localparam logic [3:0] S_SORT_END   = 4'd6;
  localparam logic [3:0] S_EMIT_START = 4'd7;
  localparam logic [3:0] S_EMIT_RD    = 4'd8;
  localparam logic [3:0] S_EMIT_OUT   = 4'd9;

  logic [3:0]       state;
  logic [CW-1:0]    count;
  logic             emit_after;
  logic [AW-1:0]    lim;
  logic [AW-1:0]    pos;
  logic [AW-1:0]    idx;
  tsts_pkg::score_t carry;
  tsts_pkg::score_t val;

  tsts_pkg::score_t mem [TABLE_DEPTH];
  tsts_pkg::score_t rd_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  tsts_pkg::score_t wr_data;

  logic             accept;
  logic             has_room;
  logic             has_place;
  logic [CW-1:0]    cnt_m1;
  logic [CW-1:0]    idx_p1;
  logic             emit_last;
  logic             out_free;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign has_room  = (count < CW'(TABLE_DEPTH));
  assign has_place = (count < CW'(PLACE_LIM));
  assign cnt_m1    = count - CW'(1);
  assign idx_p1    = CW'(idx) + CW'(1);
  assign emit_last = (idx_p1 == count) || (32'(idx) == tsts_pkg::MAX_EMIT - 1);
  assign out_free  = !out_valid || !out_stall;

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = carry;
    unique case (state)
      S_IDLE: begin
        wr_addr = count[AW-1:0];
        wr_data = score_value;
        if (accept && operation == tsts_pkg::OP_LOAD) begin
          wr_en = has_room;
        end else if (accept && operation == tsts_pkg::OP_SUBMIT) begin
          wr_en = has_place;
        end
      end
      S_SUB_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(PLACE_LIM - 1);
      end
      S_SUB_CMP: begin
        wr_en   = (val > rd_data);
        wr_addr = AW'(PLACE_LIM - 1);
        wr_data = val;
      end
      S_SORT_START: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      S_SORT_FIRST: begin
        rd_en   = 1'b1;
        rd_addr = AW'(1);
      end
      S_SORT_RUN: begin
        // carry holds the smaller value bubbling toward the end of the pass
        wr_en   = 1'b1;
        wr_addr = pos;
        wr_data = (carry < rd_data) ? rd_data : carry;
        rd_en   = (pos + AW'(1) != lim);
        rd_addr = pos + AW'(2);
      end
      S_SORT_END: begin
        wr_en   = 1'b1;
        wr_addr = lim;
        wr_data = carry;
        rd_en   = (lim != AW'(1));
        rd_addr = '0;
      end
      S_EMIT_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      emit_after <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (state == S_EMIT_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (operation)
              tsts_pkg::OP_LOAD: begin
                if (has_room) begin
                  count <= count + CW'(1);
                end
              end
              tsts_pkg::OP_SUBMIT: begin
                emit_after <= 1'b1;
                if (has_place) begin
                  count <= count + CW'(1);
                  state <= S_SORT_START;
                end else begin
                  state <= S_SUB_RD;
                end
              end
              tsts_pkg::OP_SORT: begin
                emit_after <= 1'b0;
                state      <= S_SORT_START;
              end
              tsts_pkg::OP_LIST: begin
                state <= S_EMIT_START;
              end
            endcase
          end
        end
        S_SUB_RD: begin
          state <= S_SUB_CMP;
        end
        S_SUB_CMP: begin
          state <= S_SORT_START;
        end
        S_SORT_START: begin
          if (count < CW'(2)) begin
            state <= emit_after ? S_EMIT_START : S_IDLE;
          end else begin
            state <= S_SORT_FIRST;
          end
        end
        S_SORT_FIRST: begin
          state <= S_SORT_RUN;
        end
        S_SORT_RUN: begin
          if (pos + AW'(1) == lim) begin
            state <= S_SORT_END;
          end
        end
        S_SORT_END: begin
          if (lim == AW'(1)) begin
            state <= emit_after ? S_EMIT_START : S_IDLE;
          end else begin
            state <= S_SORT_FIRST;
          end
        end
        S_EMIT_START: begin
          state <= (count == '0) ? S_IDLE : S_EMIT_RD;
        end
        S_EMIT_RD: begin
          state <= S_EMIT_OUT;
        end
        S_EMIT_OUT: begin
          if (out_free) begin
            state <= emit_last ? S_IDLE : S_EMIT_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      val <= score_value;
    end
    unique case (state)
      S_SORT_START: begin
        lim <= cnt_m1[AW-1:0];
      end
      S_SORT_FIRST: begin
        carry <= rd_data;
        pos   <= '0;
      end
      S_SORT_RUN: begin
        if (!(carry < rd_data)) begin
          carry <= rd_data;
        end
        pos <= pos + AW'(1);
      end
      S_SORT_END: begin
        lim <= lim - AW'(1);
      end
      S_EMIT_START: begin
        idx <= '0;
      end
      S_EMIT_OUT: begin
        if (out_free) begin
          rank      <= tsts_pkg::rank_t'(idx);
          score_out <= rd_data;
          last      <= emit_last;
          idx       <= idx + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule
